// ===== hw/rtl/kth_pkg.sv =====
`timescale 1ns / 1ps

package kth_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned AW       = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned CW       = $clog2(2 * CAPACITY);

  // operation codes
  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_ADVANCE = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // heap select
  localparam logic HEAP_LOWER = 1'b0;
  localparam logic HEAP_UPPER = 1'b1;

  // push value sources
  localparam logic [1:0] SRC_VAL = 2'd0;
  localparam logic [1:0] SRC_A   = 2'd1;
  localparam logic [1:0] SRC_B   = 2'd2;

  // datapath command codes
  localparam logic [3:0] DP_NOP       = 4'd0;
  localparam logic [3:0] DP_LATCH     = 4'd1;
  localparam logic [3:0] DP_PUSH_INIT = 4'd2;
  localparam logic [3:0] DP_PUSH_RD   = 4'd3;
  localparam logic [3:0] DP_PUSH_WV   = 4'd4;
  localparam logic [3:0] DP_PUSH_MOVE = 4'd5;
  localparam logic [3:0] DP_POP_INIT  = 4'd6;
  localparam logic [3:0] DP_POP_LAST  = 4'd7;
  localparam logic [3:0] DP_POP_RDC   = 4'd8;
  localparam logic [3:0] DP_POP_C1    = 4'd9;
  localparam logic [3:0] DP_POP_PICK  = 4'd10;
  localparam logic [3:0] DP_POP_MOVE  = 4'd11;
  localparam logic [3:0] DP_POP_END   = 4'd12;
  localparam logic [3:0] DP_ROOT      = 4'd13;
  localparam logic [3:0] DP_LDA_ROOT  = 4'd14;
  localparam logic [3:0] DP_LD_B      = 4'd15;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] kth_value;
  } out_item_t;

  typedef struct packed {
    logic [3:0] code;
    logic       heap;
    logic [1:0] src;
    logic       resp;
    logic [1:0] resp_status;
    logic       resp_kth;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic lower_empty;
    logic upper_empty;
    logic pos_zero;
    logic v_before_rd;
    logic child_lt_n;
    logic c1_before_last;
    logic swap;
  } dp_status_t;

endpackage

// ===== hw/rtl/kth_dp.sv =====
`timescale 1ns / 1ps

module kth_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kth_pkg::in_item_t   item_i,
  input  kth_pkg::dp_cmd_t    cmd_i,
  output kth_pkg::dp_status_t stat_o,
  output logic                done_o,
  output kth_pkg::out_item_t  result_o
);

  logic [31:0] lower_mem [kth_pkg::CAPACITY];
  logic [31:0] upper_mem [kth_pkg::CAPACITY];

  logic [31:0] rd_l_q, rd_u_q, rd;
  logic        rdh_q;
  logic [31:0] val_q, a_q, b_q, v_q, last_q, c1_q;
  logic [kth_pkg::AW-1:0]    pos_q, parent;
  logic [kth_pkg::CW-1:0]    child_q, child_p1;
  logic [kth_pkg::CNT_W-1:0] n_q, cnt_l_q, cnt_u_q, cnt_sel, cnt_dec;
  logic        hs_q, heap;
  logic        done_q;
  kth_pkg::out_item_t res_q;

  logic                   mem_we, mem_re;
  logic [kth_pkg::AW-1:0] mem_addr;
  logic [31:0]            mem_wd, src_val;
  logic                   right_ok;

  // true when a sits strictly nearer the root than b
  function automatic logic ahead(input logic upper, input logic [31:0] a,
                                 input logic [31:0] b);
    logic r;
    if (upper) r = $signed(a) < $signed(b);
    else       r = $signed(b) < $signed(a);
    return r;
  endfunction

  assign rd       = rdh_q ? rd_u_q : rd_l_q;
  assign heap     = (cmd_i.code == kth_pkg::DP_PUSH_INIT || cmd_i.code == kth_pkg::DP_POP_INIT
                     || cmd_i.code == kth_pkg::DP_ROOT || cmd_i.code == kth_pkg::DP_LDA_ROOT)
                    ? cmd_i.heap : hs_q;
  assign cnt_sel  = heap ? cnt_u_q : cnt_l_q;
  assign cnt_dec  = cnt_sel - 1'b1;
  assign parent   = (pos_q - 1'b1) >> 1;
  assign child_p1 = child_q + 1'b1;
  assign right_ok = child_p1 < {{(kth_pkg::CW-kth_pkg::CNT_W){1'b0}}, n_q};

  always_comb begin
    unique case (cmd_i.src)
      kth_pkg::SRC_A: src_val = a_q;
      kth_pkg::SRC_B: src_val = b_q;
      default:        src_val = val_q;
    endcase
  end

  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = pos_q;
    mem_wd   = v_q;
    unique case (cmd_i.code)
      kth_pkg::DP_PUSH_RD: begin
        mem_re   = 1'b1;
        mem_addr = parent;
      end
      kth_pkg::DP_PUSH_WV: begin
        mem_we = 1'b1;
      end
      kth_pkg::DP_PUSH_MOVE: begin
        mem_we = 1'b1;
        mem_wd = rd;
      end
      kth_pkg::DP_POP_INIT: begin
        mem_re   = 1'b1;
        mem_addr = cnt_dec[kth_pkg::AW-1:0];
      end
      kth_pkg::DP_POP_RDC: begin
        mem_re   = 1'b1;
        mem_addr = child_q[kth_pkg::AW-1:0];
      end
      kth_pkg::DP_POP_C1: begin
        mem_re   = 1'b1;
        mem_addr = child_p1[kth_pkg::AW-1:0];
      end
      kth_pkg::DP_POP_MOVE: begin
        mem_we = 1'b1;
        mem_wd = c1_q;
      end
      kth_pkg::DP_POP_END: begin
        mem_we = (n_q != '0);
        mem_wd = last_q;
      end
      kth_pkg::DP_ROOT, kth_pkg::DP_LDA_ROOT: begin
        mem_re   = 1'b1;
        mem_addr = '0;
      end
      default: ;
    endcase
  end

  // heap memories, one port each
  always_ff @(posedge clk_i) begin
    if (mem_we && heap == kth_pkg::HEAP_LOWER) lower_mem[mem_addr] <= mem_wd;
    if (mem_re && heap == kth_pkg::HEAP_LOWER) rd_l_q <= lower_mem[mem_addr];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we && heap == kth_pkg::HEAP_UPPER) upper_mem[mem_addr] <= mem_wd;
    if (mem_re && heap == kth_pkg::HEAP_UPPER) rd_u_q <= upper_mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_l_q <= '0;
      cnt_u_q <= '0;
      done_q  <= 1'b0;
      hs_q    <= 1'b0;
      rdh_q   <= 1'b0;
    end else begin
      done_q <= cmd_i.resp;
      if (mem_re) rdh_q <= heap;
      if (cmd_i.code == kth_pkg::DP_PUSH_INIT || cmd_i.code == kth_pkg::DP_POP_INIT) begin
        hs_q <= cmd_i.heap;
      end
      if (cmd_i.code == kth_pkg::DP_PUSH_INIT) begin
        if (heap) cnt_u_q <= cnt_sel + 1'b1;
        else      cnt_l_q <= cnt_sel + 1'b1;
      end else if (cmd_i.code == kth_pkg::DP_POP_INIT) begin
        if (heap) cnt_u_q <= cnt_dec;
        else      cnt_l_q <= cnt_dec;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp) begin
      res_q.status    <= cmd_i.resp_status;
      res_q.kth_value <= cmd_i.resp_kth ? b_q : '0;
    end
    unique case (cmd_i.code)
      kth_pkg::DP_LATCH:     val_q <= item_i.value;
      kth_pkg::DP_PUSH_INIT: begin
        v_q   <= src_val;
        pos_q <= cnt_sel[kth_pkg::AW-1:0];
      end
      kth_pkg::DP_PUSH_MOVE: pos_q <= parent;
      kth_pkg::DP_POP_INIT: begin
        n_q     <= cnt_dec;
        pos_q   <= '0;
        child_q <= {{(kth_pkg::CW-1){1'b0}}, 1'b1};
      end
      kth_pkg::DP_POP_LAST:  last_q <= rd;
      kth_pkg::DP_POP_C1:    c1_q <= rd;
      kth_pkg::DP_POP_PICK: begin
        if (right_ok && ahead(hs_q, rd, c1_q)) begin
          child_q <= child_p1;
          c1_q    <= rd;
        end
      end
      kth_pkg::DP_POP_MOVE: begin
        pos_q   <= child_q[kth_pkg::AW-1:0];
        child_q <= {child_q[kth_pkg::CW-2:0], 1'b1};
      end
      kth_pkg::DP_LDA_ROOT:  a_q <= rd;
      kth_pkg::DP_LD_B:      b_q <= rd;
      default: ;
    endcase
  end

  always_comb begin
    stat_o.full           = ({1'b0, cnt_l_q} + {1'b0, cnt_u_q})
                            >= (kth_pkg::CNT_W+1)'(kth_pkg::CAPACITY);
    stat_o.lower_empty    = (cnt_l_q == '0);
    stat_o.upper_empty    = (cnt_u_q == '0);
    stat_o.pos_zero       = (pos_q == '0);
    stat_o.v_before_rd    = ahead(hs_q, v_q, rd);
    stat_o.child_lt_n     = child_q < {{(kth_pkg::CW-kth_pkg::CNT_W){1'b0}}, n_q};
    stat_o.c1_before_last = ahead(hs_q, c1_q, last_q);
    stat_o.swap           = $signed(a_q) < $signed(b_q);
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ===== hw/rtl/kth_ctrl.sv =====
`timescale 1ns / 1ps

module kth_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [1:0]          op_i,
  input  kth_pkg::dp_status_t stat_i,
  output logic                busy_o,
  output kth_pkg::dp_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_NEXT    = 4'd1;
  localparam logic [3:0] S_PU_RD   = 4'd2;
  localparam logic [3:0] S_PU_CMP  = 4'd3;
  localparam logic [3:0] S_PO_LAST = 4'd4;
  localparam logic [3:0] S_PO_RDC  = 4'd5;
  localparam logic [3:0] S_PO_C1   = 4'd6;
  localparam logic [3:0] S_PO_PICK = 4'd7;
  localparam logic [3:0] S_PO_DEC  = 4'd8;
  localparam logic [3:0] S_RT_B    = 4'd9;
  localparam logic [3:0] S_RT_C    = 4'd10;

  logic [3:0] state_q, state_d;
  logic [2:0] step_q, step_d;
  logic [1:0] op_q, op_d;

  // launch helpers
  function automatic kth_pkg::dp_cmd_t mk(input logic [3:0] code, input logic heap,
                                          input logic [1:0] src);
    kth_pkg::dp_cmd_t c;
    c      = '0;
    c.code = code;
    c.heap = heap;
    c.src  = src;
    return c;
  endfunction

  function automatic kth_pkg::dp_cmd_t rsp(input logic [1:0] st, input logic kth);
    kth_pkg::dp_cmd_t c;
    c             = '0;
    c.resp        = 1'b1;
    c.resp_status = st;
    c.resp_kth    = kth;
    return c;
  endfunction

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    op_d    = op_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o   = mk(kth_pkg::DP_LATCH, kth_pkg::HEAP_LOWER, kth_pkg::SRC_VAL);
          op_d    = op_i;
          step_d  = '0;
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        step_d = step_q + 1'b1;
        unique case (op_q)
          kth_pkg::OP_INSERT: begin
            unique case (step_q)
              3'd0: begin
                if (stat_i.full) begin
                  cmd_o   = rsp(kth_pkg::ST_FULL, 1'b0);
                  state_d = S_IDLE;
                end else begin
                  cmd_o   = mk(kth_pkg::DP_PUSH_INIT, kth_pkg::HEAP_UPPER, kth_pkg::SRC_VAL);
                  state_d = S_PU_RD;
                end
              end
              3'd1: begin
                if (stat_i.lower_empty) begin
                  cmd_o   = rsp(kth_pkg::ST_OK, 1'b0);
                  state_d = S_IDLE;
                end else begin
                  cmd_o   = mk(kth_pkg::DP_ROOT, kth_pkg::HEAP_UPPER, kth_pkg::SRC_VAL);
                  state_d = S_RT_B;
                end
              end
              3'd2: begin
                if (!stat_i.swap) begin
                  cmd_o   = rsp(kth_pkg::ST_OK, 1'b0);
                  state_d = S_IDLE;
                end else begin
                  cmd_o   = mk(kth_pkg::DP_POP_INIT, kth_pkg::HEAP_UPPER, kth_pkg::SRC_VAL);
                  state_d = S_PO_LAST;
                end
              end
              3'd3: begin
                cmd_o   = mk(kth_pkg::DP_PUSH_INIT, kth_pkg::HEAP_UPPER, kth_pkg::SRC_B);
                state_d = S_PU_RD;
              end
              3'd4: begin
                cmd_o   = mk(kth_pkg::DP_POP_INIT, kth_pkg::HEAP_LOWER, kth_pkg::SRC_VAL);
                state_d = S_PO_LAST;
              end
              3'd5: begin
                cmd_o   = mk(kth_pkg::DP_PUSH_INIT, kth_pkg::HEAP_LOWER, kth_pkg::SRC_A);
                state_d = S_PU_RD;
              end
              default: begin
                cmd_o   = rsp(kth_pkg::ST_OK, 1'b0);
                state_d = S_IDLE;
              end
            endcase
          end
          kth_pkg::OP_ADVANCE: begin
            unique case (step_q)
              3'd0: begin
                if (stat_i.upper_empty) begin
                  cmd_o   = rsp(kth_pkg::ST_EMPTY, 1'b0);
                  state_d = S_IDLE;
                end else begin
                  cmd_o   = mk(kth_pkg::DP_ROOT, kth_pkg::HEAP_UPPER, kth_pkg::SRC_VAL);
                  state_d = S_RT_B;
                end
              end
              3'd1: begin
                cmd_o   = mk(kth_pkg::DP_PUSH_INIT, kth_pkg::HEAP_LOWER, kth_pkg::SRC_A);
                state_d = S_PU_RD;
              end
              3'd2: begin
                cmd_o   = mk(kth_pkg::DP_POP_INIT, kth_pkg::HEAP_UPPER, kth_pkg::SRC_VAL);
                state_d = S_PO_LAST;
              end
              default: begin
                cmd_o   = rsp(kth_pkg::ST_OK, 1'b0);
                state_d = S_IDLE;
              end
            endcase
          end
          kth_pkg::OP_QUERY: begin
            if (step_q == 3'd0) begin
              if (stat_i.lower_empty) begin
                cmd_o   = rsp(kth_pkg::ST_EMPTY, 1'b0);
                state_d = S_IDLE;
              end else begin
                cmd_o   = mk(kth_pkg::DP_ROOT, kth_pkg::HEAP_UPPER, kth_pkg::SRC_VAL);
                state_d = S_RT_B;
              end
            end else begin
              cmd_o   = rsp(kth_pkg::ST_OK, 1'b1);
              state_d = S_IDLE;
            end
          end
          default: begin
            cmd_o   = rsp(kth_pkg::ST_OK, 1'b0);
            state_d = S_IDLE;
          end
        endcase
      end
      // sift up
      S_PU_RD: begin
        if (stat_i.pos_zero) begin
          cmd_o   = mk(kth_pkg::DP_PUSH_WV, kth_pkg::HEAP_LOWER, kth_pkg::SRC_VAL);
          state_d = S_NEXT;
        end else begin
          cmd_o   = mk(kth_pkg::DP_PUSH_RD, kth_pkg::HEAP_LOWER, kth_pkg::SRC_VAL);
          state_d = S_PU_CMP;
        end
      end
      S_PU_CMP: begin
        if (stat_i.v_before_rd) begin
          cmd_o   = mk(kth_pkg::DP_PUSH_MOVE, kth_pkg::HEAP_LOWER, kth_pkg::SRC_VAL);
          state_d = S_PU_RD;
        end else begin
          cmd_o   = mk(kth_pkg::DP_PUSH_WV, kth_pkg::HEAP_LOWER, kth_pkg::SRC_VAL);
          state_d = S_NEXT;
        end
      end
      // sift down
      S_PO_LAST: begin
        cmd_o   = mk(kth_pkg::DP_POP_LAST, kth_pkg::HEAP_LOWER, kth_pkg::SRC_VAL);
        state_d = S_PO_RDC;
      end
      S_PO_RDC: begin
        if (stat_i.child_lt_n) begin
          cmd_o   = mk(kth_pkg::DP_POP_RDC, kth_pkg::HEAP_LOWER, kth_pkg::SRC_VAL);
          state_d = S_PO_C1;
        end else begin
          cmd_o   = mk(kth_pkg::DP_POP_END, kth_pkg::HEAP_LOWER, kth_pkg::SRC_VAL);
          state_d = S_NEXT;
        end
      end
      S_PO_C1: begin
        cmd_o   = mk(kth_pkg::DP_POP_C1, kth_pkg::HEAP_LOWER, kth_pkg::SRC_VAL);
        state_d = S_PO_PICK;
      end
      S_PO_PICK: begin
        cmd_o   = mk(kth_pkg::DP_POP_PICK, kth_pkg::HEAP_LOWER, kth_pkg::SRC_VAL);
        state_d = S_PO_DEC;
      end
      S_PO_DEC: begin
        if (stat_i.c1_before_last) begin
          cmd_o   = mk(kth_pkg::DP_POP_MOVE, kth_pkg::HEAP_LOWER, kth_pkg::SRC_VAL);
          state_d = S_PO_RDC;
        end else begin
          cmd_o   = mk(kth_pkg::DP_POP_END, kth_pkg::HEAP_LOWER, kth_pkg::SRC_VAL);
          state_d = S_NEXT;
        end
      end
      // root fetch
      S_RT_B: begin
        cmd_o   = mk(kth_pkg::DP_LDA_ROOT, kth_pkg::HEAP_LOWER, kth_pkg::SRC_VAL);
        state_d = S_RT_C;
      end
      S_RT_C: begin
        cmd_o   = mk(kth_pkg::DP_LD_B, kth_pkg::HEAP_LOWER, kth_pkg::SRC_VAL);
        state_d = S_NEXT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      op_q    <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      op_q    <= op_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== hw/rtl/kth_smallest_two_heap_tracker.sv =====
`timescale 1ns / 1ps

// k-th smallest tracker: the k smallest values live in a max-heap (lower),
// all others in a min-heap (upper); the lower root is the k-th smallest.
// an item is taken when start_i is high and busy_o low; its single result
// appears for exactly one cycle with done_o high and cannot be held off.
// how long an item takes depends on the sift loops over the two
// single-port heap memories: a sift-up level reads the parent and then
// compares, a sift-down level reads both children, picks one and compares
// it with the last entry, and root fetch reads both roots; query and
// rejected items run no sift, an insert that exchanges roots runs three
// sift-ups and two sift-downs. no clearing pass is needed after reset: a
// value read at or above a heap's count is never used.

module kth_smallest_two_heap_tracker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  kth_pkg::in_item_t  item_i,
  output logic               done_o,
  output kth_pkg::out_item_t result_o
);

  // command and status between sequencer and datapath
  kth_pkg::dp_cmd_t    cmd;
  kth_pkg::dp_status_t stat;

  kth_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .op_i   (item_i.operation),
    .stat_i (stat),
    .busy_o (busy_o),
    .cmd_o  (cmd)
  );

  kth_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // a result strobe is never held
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");

  // a transfer makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("transfer not taken");

  // only a good query carries a value
  a_kth_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != kth_pkg::ST_OK) |-> (result_o.kth_value == '0))
    else $error("value on failed item");

  // a result comes only after busy
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("result without work");

endmodule
